@@ rtl/huffman_tree_table_decoder_assert.svh @@
// Assertion macros for the Huffman tree-table decoder
`ifndef HUFFMAN_TREE_TABLE_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_TABLE_DECODER_ASSERT_SVH

// check cons in the same cycle as ante
`define HTD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htd assertion failed");

// check cons in the cycle after ante
`define HTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htd assertion failed");

`endif

@@ rtl/htd_pkg.sv @@
// Types and constants shared by the Huffman tree-table decoder
package htd_pkg;

  localparam int TABLE_BYTES = 512;
  localparam int TABLE_AW    = $clog2(TABLE_BYTES);
  localparam int POS_W       = 9;
  localparam int NODE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int CODE_BITS   = 32;
  localparam int BITS_W      = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int LEAF0_BIT   = 7;
  localparam int LEAF1_BIT   = 6;

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_ROOT = 9'd1;

  localparam logic OP_TABLE = 1'b0;
  localparam logic OP_CODE  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_LENGTH = 2'd1;

  typedef struct packed {
    logic              op;
    logic [POS_W-1:0]  table_address;
    logic [NODE_W-1:0] table_byte;
    logic [WORD_W-1:0] code_word;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic [2:0]        byte_count;
    logic              last_of_item;
    logic              finished;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_BIT   = 5'b00100,
    S_LEAF  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  function automatic logic in_table(input pos_t pos);
    logic [POS_W:0] wide;
    wide = {1'b0, pos};
    return wide < (POS_W+1)'(TABLE_BYTES);
  endfunction

endpackage

@@ rtl/htd_ram.sv @@
// Generic single-port-write, registered-read RAM
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/huffman_tree_table_decoder.sv @@
// Top level of the Huffman tree-table decoder.
// Table write: taken while idle. Code word: taken while idle, then a start step, then a BIT
// step per code bit plus a LEAF step per leaf, bound by the node table's registered read port;
// a LEAF step can stall on a pending result, and a FLUSH step hands off the final result.
// Reset (synchronous, rst_n low) restarts the walk at the root, clears the collector and
// counters, sets symbol_mode to 1 and output_length to 0; table contents stay undefined.
`include "huffman_tree_table_decoder_assert.svh"

module huffman_tree_table_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  htd_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output htd_pkg::result_t                 out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [htd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [htd_pkg::WORD_W-1:0]       cfg_data
);

  import htd_pkg::*;

  state_t              state_r;
  logic                mode_r;
  logic [WORD_W-1:0]   len_r;
  pos_t                pos_r;
  logic [WORD_W-1:0]   col_r;
  logic [3:0]          sc_r;
  logic [WORD_W-1:0]   bytes_r;
  logic                done_r;
  logic [WORD_W-1:0]   code_r;
  logic [BITS_W-1:0]   bits_left_r;
  logic [WORD_W-1:0]   rem_r;
  logic                rd_oob_r;
  result_t             pend_r;
  logic                pend_v_r;
  result_t             out_r;
  logic                out_valid_r;

  logic                in_accept;
  logic                ram_wr_en;
  logic                ram_rd_en;
  pos_t                ram_rd_pos;
  logic [NODE_W-1:0]   ram_rd_data;
  logic [NODE_W-1:0]   node;
  logic                code_bit;
  logic                leaf;
  pos_t                next_pos;
  logic [WORD_W:0]     diff;
  logic                skip;
  logic [WORD_W-1:0]   col_leaf;
  logic [3:0]          sc_inc;
  logic [3:0]          reach;
  logic                full;
  logic                reach_ge;
  logic                emit;
  logic [2:0]          shift_nib;
  logic [2:0]          tmp_b;
  logic [3:0]          tmp_n;
  logic [WORD_W-1:0]   data_sh;
  logic [2:0]          count;
  logic [WORD_W-1:0]   mask;
  logic                fin_emit;
  logic                out_free;
  logic                leaf_go;
  logic                mv_leaf;
  logic                mv_flush;
  result_t             res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ram_wr_en = in_accept && (in_data.op == OP_TABLE) && in_table(in_data.table_address);

  htd_ram #(
    .WIDTH(NODE_W),
    .DEPTH(TABLE_BYTES)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(in_data.table_address[TABLE_AW-1:0]),
    .wr_data(in_data.table_byte),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_pos[TABLE_AW-1:0]),
    .rd_data(ram_rd_data)
  );

  assign node     = rd_oob_r ? '0 : ram_rd_data;
  assign code_bit = code_r[WORD_W-1];
  assign leaf     = code_bit ? node[LEAF1_BIT] : node[LEAF0_BIT];
  assign next_pos = {pos_r[POS_W-1:1], 1'b0}
                  + {1'b0, ({1'b0, node[5:0]} + 7'd1), 1'b0}
                  + {{(POS_W-1){1'b0}}, code_bit};

  assign diff = {1'b0, len_r} - {1'b0, bytes_r};
  assign skip = done_r || diff[WORD_W] || (diff[WORD_W-1:0] == '0);

  assign col_leaf = mode_r ? {node, col_r[WORD_W-1:8]} : {node[3:0], col_r[WORD_W-1:4]};
  assign sc_inc   = (sc_r == 4'd15) ? sc_r : sc_r + 4'd1;
  assign reach    = mode_r ? sc_inc : {1'b0, sc_inc[3:1]};
  assign full     = mode_r ? (sc_inc >= 4'd4) : (sc_inc >= 4'd8);
  assign reach_ge = (rem_r[WORD_W-1:4] == '0) && (reach >= rem_r[3:0]);
  assign emit     = reach_ge || full;

  assign tmp_b     = 3'd4 - sc_inc[2:0];
  assign tmp_n     = 4'd8 - sc_inc;
  assign shift_nib = mode_r ? {tmp_b[1:0], 1'b0} : tmp_n[2:0];
  assign data_sh   = (reach_ge && !full) ? (col_leaf >> {shift_nib, 2'b00}) : col_leaf;

  assign count    = (rem_r[WORD_W-1:2] == '0) ? rem_r[2:0] : 3'd4;
  assign fin_emit = (rem_r[WORD_W-1:3] == '0) && (rem_r[2:0] <= 3'd4);

  always_comb begin
    case (count)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    res              = '0;
    res.out_word     = data_sh & mask;
    res.byte_count   = count;
    res.last_of_item = 1'b0;
    res.finished     = fin_emit;
  end

  assign out_free = !out_valid_r || out_ready;
  assign leaf_go  = !emit || !pend_v_r || out_free;
  assign mv_leaf  = (state_r == S_LEAF) && leaf_go && emit && pend_v_r;
  assign mv_flush = (state_r == S_FLUSH) && pend_v_r && out_free;

  always_comb begin
    ram_rd_en  = 1'b0;
    ram_rd_pos = pos_r;
    unique case (state_r)
      S_START: begin
        ram_rd_en  = !skip;
        ram_rd_pos = pos_r;
      end
      S_BIT: begin
        ram_rd_en  = 1'b1;
        ram_rd_pos = next_pos;
      end
      S_LEAF: begin
        ram_rd_en  = leaf_go;
        ram_rd_pos = POS_ROOT;
      end
      default: begin
        ram_rd_en  = 1'b0;
        ram_rd_pos = pos_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b1;
      len_r       <= '0;
      pos_r       <= POS_ROOT;
      col_r       <= '0;
      sc_r        <= '0;
      bytes_r     <= '0;
      done_r      <= 1'b0;
      bits_left_r <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYMBOL_MODE:   mode_r <= cfg_data[0];
          CFG_OUTPUT_LENGTH: len_r  <= cfg_data;
          default: ;
        endcase
      end

      if (mv_leaf || mv_flush) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            if (in_data.op == OP_TABLE) begin
              pos_r   <= POS_ROOT;
              col_r   <= '0;
              sc_r    <= '0;
              bytes_r <= '0;
              done_r  <= 1'b0;
            end else begin
              bits_left_r <= BITS_W'(CODE_BITS);
              state_r     <= S_START;
            end
          end
        end
        S_START: begin
          state_r <= skip ? S_IDLE : S_BIT;
        end
        S_BIT: begin
          pos_r       <= next_pos;
          bits_left_r <= bits_left_r - BITS_W'(1);
          if (leaf) begin
            state_r <= S_LEAF;
          end else if (bits_left_r == BITS_W'(1)) begin
            state_r <= S_FLUSH;
          end
        end
        S_LEAF: begin
          if (leaf_go) begin
            pos_r <= POS_ROOT;
            col_r <= col_leaf;
            if (emit) begin
              sc_r     <= '0;
              bytes_r  <= bytes_r + WORD_W'(count);
              done_r   <= fin_emit;
              pend_v_r <= 1'b1;
            end else begin
              sc_r <= sc_inc;
            end
            if ((emit && fin_emit) || (bits_left_r == '0)) begin
              state_r <= S_FLUSH;
            end else begin
              state_r <= S_BIT;
            end
          end
        end
        S_FLUSH: begin
          if (mv_flush) begin
            pend_v_r <= 1'b0;
          end
          if (!pend_v_r || out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ram_rd_en) begin
      rd_oob_r <= !in_table(ram_rd_pos);
    end
    if (in_accept) begin
      code_r <= in_data.code_word;
    end else if (state_r == S_BIT) begin
      code_r <= {code_r[WORD_W-2:0], 1'b0};
    end
    if (state_r == S_START) begin
      rem_r <= diff[WORD_W-1:0];
    end else if ((state_r == S_LEAF) && leaf_go && emit) begin
      rem_r <= rem_r - WORD_W'(count);
    end
    if ((state_r == S_LEAF) && leaf_go && emit) begin
      pend_r <= res;
    end
    if (mv_leaf || mv_flush) begin
      out_r <= '{out_word:     pend_r.out_word,
                 byte_count:   pend_r.byte_count,
                 last_of_item: mv_flush,
                 finished:     pend_r.finished};
    end
  end

  `HTD_ASSERT_NOW(a_idle_no_pending, state_r == S_IDLE, !pend_v_r)
  `HTD_ASSERT_NOW(a_count_range, out_valid, 3'(out_data.byte_count - 3'd1) < 3'd4)
  `HTD_ASSERT_NOW(a_finished_is_last, out_valid && out_data.finished, out_data.last_of_item)
  `HTD_ASSERT_NEXT(a_emit_clears_count, (state_r == S_LEAF) && leaf_go && emit, sc_r == 4'd0)
  `HTD_ASSERT_NOW(a_walk_has_room, (state_r == S_BIT) || (state_r == S_LEAF), rem_r != '0)

endmodule

@@ verif/huffman_tree_table_decoder_tb.sv @@
// Testbench for the Huffman tree-table decoder: directed and random traffic checked against a predictor
module huffman_tree_table_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htd_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_ITEMS  = 310;
  localparam int MAX_GAP       = 14;
  localparam longint WATCHDOG_NS = 64'd10_000_000;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct {
    in_word_t word;
    bit       drain;
  } feed_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_word_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  result_t                out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]      cfg_data  = '0;

  logic in_acc  = 1'b0;
  logic out_acc = 1'b0;
  int   in_gap  = 0;
  int   out_gap = 0;
  bit   calm    = 1'b0;
  int   errors  = 0;
  int   sent_items = 0;

  feed_t   feed_q[$];
  result_t result_q[$];

  logic [NODE_W-1:0] node_mem [TABLE_BYTES];
  pos_t              walk_pos  = POS_ROOT;
  logic [WORD_W-1:0] collector = '0;
  int unsigned       sym_cnt   = 0;
  logic [WORD_W-1:0] emitted   = '0;
  bit                done      = 1'b0;
  bit                mode_8    = 1'b1;
  logic [WORD_W-1:0] out_len   = '0;

  huffman_tree_table_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  task automatic decode_item(input in_word_t w);
    int unsigned width;
    int unsigned per_word;
    int unsigned nxt;
    int unsigned count;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] sym;
    logic [WORD_W-1:0] data;
    longint remaining;
    longint reach;
    bit b;
    bit leaf;
    bit fin;
    bit have;
    result_t r;
    result_t held;
    have = 1'b0;
    if (w.op == OP_TABLE) begin
      node_mem[w.table_address] = w.table_byte;
      walk_pos = POS_ROOT;
      collector = '0;
      sym_cnt = 0;
      emitted = '0;
      done = 1'b0;
      return;
    end
    if (done || emitted >= out_len) return;
    width = mode_8 ? 8 : 4;
    per_word = mode_8 ? 4 : 8;
    for (int i = 0; i < CODE_BITS; i++) begin
      b = w.code_word[CODE_BITS-1-i];
      node = node_mem[walk_pos];
      leaf = b ? node[LEAF1_BIT] : node[LEAF0_BIT];
      nxt = (int'(walk_pos) & ~1) + (int'(node[5:0]) + 1) * 2 + int'(b);
      walk_pos = pos_t'(nxt);
      if (!leaf) continue;
      sym = node_mem[walk_pos];
      collector = (collector >> width) | (32'(sym) << (32 - width));
      walk_pos = POS_ROOT;
      if (sym_cnt < 15) sym_cnt++;
      remaining = longint'(out_len) - longint'(emitted);
      reach = longint'((sym_cnt * width) >> 3);
      data = collector;
      if (reach >= remaining) begin
        if (sym_cnt < per_word) data = data >> (width * (per_word - sym_cnt));
      end else if (sym_cnt < per_word) begin
        continue;
      end
      count = (remaining < 4) ? int'(remaining) : 4;
      if (count < 4) data = data & ((32'd1 << (8 * count)) - 32'd1);
      sym_cnt = 0;
      emitted = emitted + count;
      fin = emitted >= out_len;
      r.out_word = data;
      r.byte_count = 3'(count);
      r.last_of_item = 1'b0;
      r.finished = fin;
      if (have) result_q.push_back(held);
      held = r;
      have = 1'b1;
      if (fin) begin
        done = 1'b1;
        break;
      end
    end
    if (have) begin
      held.last_of_item = 1'b1;
      result_q.push_back(held);
    end
  endtask

  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) decode_item(in_data);
  end

  always @(posedge clk) begin
    out_acc <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, got word %h count %0d last %0b fin %0b", $time,
                 out_data.out_word, out_data.byte_count, out_data.last_of_item,
                 out_data.finished);
        errors++;
      end else begin
        if (out_data.out_word !== result_q[0].out_word ||
            out_data.byte_count !== result_q[0].byte_count ||
            out_data.last_of_item !== result_q[0].last_of_item ||
            out_data.finished !== result_q[0].finished) begin
          $display("%0t: mismatch, expected word %h count %0d last %0b fin %0b", $time,
                   result_q[0].out_word, result_q[0].byte_count, result_q[0].last_of_item,
                   result_q[0].finished);
          $display("%0t:           got word %h count %0d last %0b fin %0b", $time,
                   out_data.out_word, out_data.byte_count, out_data.last_of_item,
                   out_data.finished);
          errors++;
        end
        void'(result_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) in_gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (in_valid && !in_acc) begin
        // hold the word until taken
      end else if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (feed_q.size() != 0 && !(feed_q[0].drain && result_q.size() != 0)) begin
        in_data <= feed_q[0].word;
        void'(feed_q.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_acc) out_gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (out_gap != 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_word_t table_item(input logic [POS_W-1:0] a,
                                          input logic [NODE_W-1:0] v);
    in_word_t w;
    w.op = OP_TABLE;
    w.table_address = a;
    w.table_byte = v;
    w.code_word = $urandom;
    return w;
  endfunction

  function automatic in_word_t code_item(input logic [WORD_W-1:0] c);
    in_word_t w;
    w.op = OP_CODE;
    w.table_address = POS_W'($urandom);
    w.table_byte = NODE_W'($urandom);
    w.code_word = c;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] rand_code();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic put(input in_word_t w, input bit drain = 1'b0);
    feed_t f;
    f.word = w;
    f.drain = drain;
    feed_q.push_back(f);
    sent_items++;
  endtask

  task automatic settle();
    do @(posedge clk); while (feed_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SYMBOL_MODE) mode_8 = val[0];
    else if (idx == CFG_OUTPUT_LENGTH) out_len = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int base;
    int n;
    logic [WORD_W-1:0] len;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int a = 0; a < TABLE_BYTES; a++) put(table_item(POS_W'(a), NODE_W'($urandom)));
    settle();

    put(code_item('1));
    settle();
    set_reg(CFG_OUTPUT_LENGTH, '1);
    set_reg(CFG_SPARE_2, $urandom);
    set_reg(CFG_SPARE_3, $urandom);
    put(code_item('0));
    put(code_item('1));
    put(code_item(32'hAAAA_AAAA));
    put(code_item(32'h5555_5555));
    put(table_item('1, '1));
    put(code_item($urandom));
    put(table_item('0, '0));
    put(code_item($urandom));
    settle();
    set_reg(CFG_SYMBOL_MODE, 32'd0);
    repeat (3) put(code_item($urandom));
    settle();
    set_reg(CFG_SYMBOL_MODE, 32'd1);
    put(code_item($urandom));
    settle();
    set_reg(CFG_SYMBOL_MODE, 32'd0);
    set_reg(CFG_OUTPUT_LENGTH, 32'd1);
    put(table_item(POS_W'($urandom), NODE_W'($urandom)));
    put(code_item('1));
    put(code_item($urandom));
    settle();
    set_reg(CFG_SYMBOL_MODE, 32'd1);
    set_reg(CFG_OUTPUT_LENGTH, 32'd3);
    put(table_item(POS_W'($urandom), NODE_W'($urandom)));
    put(code_item($urandom));
    put(code_item($urandom));
    settle();
    set_reg(CFG_SYMBOL_MODE, 32'd0);
    set_reg(CFG_OUTPUT_LENGTH, 32'd5);
    put(table_item(POS_W'($urandom), NODE_W'($urandom)));
    put(code_item($urandom));
    put(code_item($urandom), 1'b1);

    settle();
    base = sent_items;
    while (sent_items - base < RANDOM_ITEMS) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0: len = '0;
        1: len = '1;
        2: len = $urandom;
        3: len = $urandom_range(1, 4);
        default: len = $urandom_range(1, 48);
      endcase
      if ($urandom_range(0, 3) != 0) set_reg(CFG_OUTPUT_LENGTH, len);
      if ($urandom_range(0, 1) != 0) set_reg(CFG_SYMBOL_MODE, $urandom);
      if ($urandom_range(0, 7) == 0) begin
        set_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
      end
      n = (out_len < 8) ? $urandom_range(2, 5) : $urandom_range(4, 16);
      if ($urandom_range(0, 3) != 0) put(table_item(POS_W'($urandom), NODE_W'($urandom)));
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          put(table_item(POS_W'($urandom), NODE_W'($urandom)));
        end else begin
          put(code_item(rand_code()), $urandom_range(0, 15) == 0);
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
